// ===== src/bica_pkg.sv =====
// Package for the chunk allocator: sizes, codes and the sequencer state type.
// No dependencies; used by bica_div, the top level and the checker.
`default_nettype none
package bica_pkg;
    localparam int MAX_CHUNKS = 1024;
    localparam int CIW   = $clog2(MAX_CHUNKS);      // chunk index width
    localparam int CNT_W = $clog2(MAX_CHUNKS + 1);  // chunk count width
    localparam int CB_W  = 13;
    localparam int ID_W  = 8;
    localparam logic [ID_W-1:0] MAP_ID   = 8'd5;
    localparam logic [CB_W-1:0] CB_MAX   = 13'd4096;

    localparam logic [1:0] K_FORMAT = 2'd0;
    localparam logic [1:0] K_ALLOC  = 2'd1;
    localparam logic [1:0] K_FREE   = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NOROOM = 2'd1;
    localparam logic [1:0] ST_RANGE  = 2'd2;

    localparam logic [1:0] CFG_BASE  = 2'd0;
    localparam logic [1:0] CFG_DATA  = 2'd1;
    localparam logic [1:0] CFG_CHUNK = 2'd2;

    typedef enum logic [4:0] {
        S_IDLE, S_FDIV1, S_FDIV2, S_FSWEEP,
        S_ADIV, S_CHK, S_EVAL, S_RDL, S_RDR, S_PICK, S_AWR,
        S_XDIV, S_XRD, S_XID, S_XWR, S_XCMP, S_FIN
    } t_state;
endpackage
`default_nettype wire

// ===== src/bica_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module bica_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== src/bica_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on bica_pkg for the divisor width.
`default_nettype none
module bica_div (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    input  wire logic [31:0]              i_dividend,
    input  wire logic [bica_pkg::CB_W-1:0] i_divisor,
    output logic                          o_done,
    output logic      [31:0]              o_quot,
    output logic      [bica_pkg::CB_W-1:0] o_rem
);
    import bica_pkg::*;

    logic [5:0]      r_cnt;
    logic [CB_W-1:0] r_d;
    logic [CB_W:0]   w_sh;
    logic            w_ge;

    assign w_sh = {o_rem, o_quot[31]};
    assign w_ge = w_sh >= {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= (r_cnt == 6'd1);
            if (i_start) begin
                r_cnt <= 6'd32;
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 6'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            o_quot <= i_dividend;
            o_rem  <= '0;
            r_d    <= i_divisor;
        end else if (r_cnt != '0) begin
            o_quot <= {o_quot[30:0], w_ge};
            o_rem  <= w_ge ? CB_W'(w_sh - {1'b0, r_d}) : w_sh[CB_W-1:0];
        end
    end
endmodule
`default_nettype wire

// ===== src/bitmap_id_chunk_allocator_top.sv =====
// Chunk allocator top level: config registers, sequencer, owner-id RAM.
// Depends on bica_pkg, bica_ram and bica_div.
//
// Usage: write base_address, data_bytes and chunk_bytes through the plain
// write port (i_cfg_we, i_cfg_idx, i_cfg_data) while the block is idle.
// A command word is taken when i_start is high and o_busy is low. Exactly
// one result follows, shown with o_done for one cycle; the receiver must
// take it then. o_busy drops in that same cycle, so the next command can
// be taken at once.
// Steps per command: format runs two divides and then one sweep of the
// RAM; allocate runs a divide, scans the RAM for a free run of chunks and
// writes the new owner id into it; free runs a divide, reads the owner id
// at the address and clears the run of chunks that hold it; failures
// caught up front skip straight to the result.
// Commands are handled one at a time; the owner-id RAM read port (one
// read per cycle, registered read data) paces the scan, which reads and
// then evaluates each chunk. Reset clears the config to its defaults and
// the counters to zero; the RAM holds no meaning until the first format.
`default_nettype none
module bitmap_id_chunk_allocator_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    output logic             o_busy,
    input  wire logic [1:0]  i_kind,
    input  wire logic [31:0] i_request_bytes,
    input  wire logic [31:0] i_address,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data,
    output logic             o_done,
    output logic [1:0]       o_status,
    output logic [31:0]      o_result_address,
    output logic [10:0]      o_chunks_changed,
    output logic [10:0]      o_chunks_in_use
);
    import bica_pkg::*;

    logic [31:0]      r_base, r_data;
    logic [CB_W-1:0]  r_chunk, w_cb, r_cb;
    t_state           r_state, n_state;

    logic [CNT_W-1:0] r_total, n_total, r_used, n_used, r_need, n_need;
    logic [CNT_W-1:0] r_y, n_y, r_x, n_x, r_cnt, n_cnt, r_rsv, n_rsv;
    logic [CIW-1:0]   r_mark, n_mark, r_pos, n_pos;
    logic [CNT_W:0]   r_visit, n_visit;
    logic [ID_W-1:0]  r_id, n_id, r_left, n_left;
    logic             r_done, n_done;
    logic [1:0]       r_st, n_st;
    logic [31:0]      r_ra, n_ra;
    logic [CNT_W-1:0] r_chg, n_chg;

    logic             div_start, div_done;
    logic [31:0]      div_a, div_q;
    logic [CB_W-1:0]  div_rem;
    logic [32:0]      w_ceil;

    logic             ram_we;
    logic [CIW-1:0]   ram_waddr, ram_raddr;
    logic [ID_W-1:0]  ram_wdata, w_rd;

    logic [CNT_W-1:0] w_free, w_pos_y, w_ny, w_pos_ny, w_pos_need, w_x1, w_sub;
    logic [CNT_W+CB_W-1:0] w_room, w_pos_cb;
    logic             w_req_bad, w_need_big, w_idx_big, w_scan_end;
    logic             w_run_ok, w_run_end, w_sweep_end, w_awr_end, w_x_end;
    logic [ID_W-1:0]  w_right, w_c0, w_c1, w_c2;
    logic [CNT_W:0]   w_mark1;

    // config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= '0;
            r_data  <= 32'd16384;
            r_chunk <= 13'd16;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_BASE:  r_base  <= i_cfg_data;
                CFG_DATA:  r_data  <= i_cfg_data;
                CFG_CHUNK: r_chunk <= i_cfg_data[CB_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_cb = (r_chunk == '0) ? CB_W'(1) : ((r_chunk > CB_MAX) ? CB_MAX : r_chunk);

    bica_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_dividend(div_a), .i_divisor(r_state == S_IDLE ? w_cb : r_cb),
        .o_done(div_done), .o_quot(div_q), .o_rem(div_rem)
    );

    bica_ram #(.WIDTH(ID_W), .DEPTH(MAX_CHUNKS)) u_ram (
        .i_clk(i_clk), .i_we(ram_we), .i_waddr(ram_waddr), .i_wdata(ram_wdata),
        .i_raddr(ram_raddr), .o_rdata(w_rd)
    );

    // shared datapath terms
    assign w_ceil     = {1'b0, div_q} + 33'(div_rem != '0);
    assign w_free     = (r_used < r_total) ? r_total - r_used : '0;
    assign w_room     = w_free * w_cb;
    assign w_req_bad  = (i_request_bytes == '0) ||
                        (32'(w_room) < i_request_bytes);
    assign w_need_big = w_ceil > 33'(r_total);
    assign w_idx_big  = div_q >= 32'(r_total);
    assign w_pos_y    = CNT_W'(r_pos) + r_y;
    assign w_ny       = r_y + CNT_W'(1);
    assign w_pos_ny   = CNT_W'(r_pos) + w_ny;
    assign w_pos_need = CNT_W'(r_pos) + r_need;
    assign w_scan_end = (r_y == '0) && (r_visit >= (CNT_W+1)'(r_total));
    assign w_run_ok   = (w_rd == '0) && (w_ny == r_need);
    assign w_run_end  = (w_rd == '0) && (w_pos_ny == r_total);
    assign w_sweep_end = (r_x[CIW-1:0] == CIW'(MAX_CHUNKS - 1));
    assign w_x1       = r_x + CNT_W'(1);
    assign w_awr_end  = (w_x1 == r_need);
    assign w_x_end    = (w_x1 >= r_total);
    assign w_mark1    = (CNT_W+1)'(r_mark) + (CNT_W+1)'(1);
    assign w_right    = (w_pos_need < r_total) ? w_rd : '0;
    assign w_c0       = r_left + ID_W'(1);
    assign w_c1       = (w_c0 == w_right || w_c0 == '0) ? w_c0 + ID_W'(1) : w_c0;
    assign w_c2       = (w_c1 == w_right || w_c1 == '0) ? w_c1 + ID_W'(1) : w_c1;
    assign w_pos_cb   = CNT_W'(r_pos) * r_cb;
    assign w_sub      = (r_used > r_cnt) ? r_used - r_cnt : '0;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    unique case (i_kind)
                        K_FORMAT: n_state = S_FDIV1;
                        K_ALLOC:  n_state = w_req_bad ? S_FIN : S_ADIV;
                        K_FREE:   n_state = (i_address < r_base) ? S_FIN : S_XDIV;
                        default:  n_state = S_FIN;
                    endcase
                end
            end
            S_FDIV1:  if (div_done) n_state = S_FDIV2;
            S_FDIV2:  if (div_done) n_state = S_FSWEEP;
            S_FSWEEP: if (w_sweep_end) n_state = S_FIN;
            S_ADIV:   if (div_done) n_state = w_need_big ? S_FIN : S_CHK;
            S_CHK:    n_state = w_scan_end ? S_FIN : S_EVAL;
            S_EVAL:   n_state = w_run_ok ? S_RDL : S_CHK;
            S_RDL:    n_state = S_RDR;
            S_RDR:    n_state = S_PICK;
            S_PICK:   n_state = S_AWR;
            S_AWR:    if (w_awr_end) n_state = S_FIN;
            S_XDIV:   if (div_done) n_state = w_idx_big ? S_FIN : S_XRD;
            S_XRD:    n_state = S_XID;
            S_XID:    n_state = (w_rd == '0) ? S_FIN : S_XWR;
            S_XWR:    n_state = w_x_end ? S_FIN : S_XCMP;
            S_XCMP:   n_state = (w_rd == r_id) ? S_XWR : S_FIN;
            S_FIN:    n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_total = r_total; n_used = r_used; n_need = r_need; n_y = r_y;
        n_x = r_x; n_cnt = r_cnt; n_rsv = r_rsv; n_mark = r_mark; n_pos = r_pos;
        n_visit = r_visit; n_id = r_id; n_left = r_left;
        n_st = r_st; n_ra = r_ra;
        n_chg = r_chg; n_done = (r_state == S_FIN);
        div_start = 1'b0; div_a = '0;
        ram_we = 1'b0; ram_waddr = '0; ram_wdata = '0; ram_raddr = '0;
        unique case (r_state)
            S_IDLE: begin
                n_st = ST_OK; n_ra = '0; n_chg = '0;
                if (i_start) begin
                    unique case (i_kind)
                        K_FORMAT: begin
                            div_start = 1'b1; div_a = r_data;
                        end
                        K_ALLOC: begin
                            if (w_req_bad) n_st = ST_NOROOM;
                            else begin
                                div_start = 1'b1; div_a = i_request_bytes;
                            end
                        end
                        K_FREE: begin
                            if (i_address < r_base) n_st = ST_RANGE;
                            else begin
                                div_start = 1'b1; div_a = i_address - r_base;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_FDIV1: if (div_done) begin
                n_total = (div_q > 32'(MAX_CHUNKS)) ? CNT_W'(MAX_CHUNKS)
                                                   : div_q[CNT_W-1:0];
                div_start = 1'b1;
                div_a = (div_q > 32'(MAX_CHUNKS)) ? 32'(MAX_CHUNKS) : div_q;
            end
            S_FDIV2: if (div_done) begin
                n_rsv = CNT_W'(w_ceil);
                n_x = '0;
            end
            S_FSWEEP: begin
                ram_we = 1'b1; ram_waddr = r_x[CIW-1:0];
                ram_wdata = (r_x < r_rsv) ? MAP_ID : '0;
                n_x = w_x1;
                if (w_sweep_end) begin
                    n_used = r_rsv; n_chg = r_rsv;
                    if (r_rsv != '0) n_mark = CIW'(r_rsv - CNT_W'(1));
                    else if (r_total != '0) n_mark = CIW'(r_total - CNT_W'(1));
                    else n_mark = '0;
                end
            end
            S_ADIV: if (div_done) begin
                if (w_need_big) n_st = ST_NOROOM;
                n_need = CNT_W'(w_ceil);
                n_pos = (w_mark1 >= (CNT_W+1)'(r_total)) ? '0 : CIW'(w_mark1);
                n_y = '0; n_visit = '0;
            end
            S_CHK: begin
                ram_raddr = CIW'(w_pos_y);
                if (w_scan_end) n_st = ST_NOROOM;
            end
            S_EVAL: begin
                if (w_rd == '0) begin
                    if (w_run_ok) n_y = w_ny;
                    else if (w_run_end) begin
                        n_pos = '0; n_visit = r_visit + (CNT_W+1)'(w_ny); n_y = '0;
                    end else n_y = w_ny;
                end else if (r_y == '0) begin
                    n_pos = (CNT_W'(r_pos) + CNT_W'(1) >= r_total) ? '0 : r_pos + CIW'(1);
                    n_visit = r_visit + (CNT_W+1)'(1);
                end else begin
                    n_pos = CIW'(w_pos_y);
                    n_visit = r_visit + (CNT_W+1)'(r_y); n_y = '0;
                end
            end
            S_RDL: ram_raddr = r_pos - CIW'(1);
            S_RDR: begin
                n_left = (r_pos == '0) ? '0 : w_rd;
                ram_raddr = CIW'(w_pos_need);
            end
            S_PICK: begin
                n_id = w_c2; n_x = '0;
            end
            S_AWR: begin
                ram_we = 1'b1; ram_waddr = r_pos + CIW'(r_x); ram_wdata = r_id;
                n_x = w_x1;
                if (w_awr_end) begin
                    n_mark = (w_pos_need >= CNT_W'(2)) ? CIW'(w_pos_need - CNT_W'(2))
                                                       : CIW'(r_total - CNT_W'(1));
                    n_used = r_used + r_need; n_chg = r_need;
                    n_ra = r_base + 32'(w_pos_cb);
                end
            end
            S_XDIV: if (div_done) begin
                if (w_idx_big) n_st = ST_RANGE;
                n_pos = div_q[CIW-1:0];
            end
            S_XRD: ram_raddr = r_pos;
            S_XID: begin
                n_id = w_rd; n_x = CNT_W'(r_pos); n_cnt = '0;
            end
            S_XWR: begin
                ram_we = 1'b1; ram_waddr = r_x[CIW-1:0];
                ram_raddr = w_x1[CIW-1:0];
                n_x = w_x1; n_cnt = r_cnt + CNT_W'(1);
                if (w_x_end) begin
                    n_chg = r_cnt + CNT_W'(1);
                    n_used = (r_used > n_chg) ? r_used - n_chg : '0;
                end
            end
            S_XCMP: if (w_rd != r_id) begin
                n_chg = r_cnt; n_used = w_sub;
            end
            S_FIN: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_done <= 1'b0; r_total <= '0; r_used <= '0;
            r_mark <= '0;
        end else begin
            r_state <= n_state; r_done <= n_done; r_total <= n_total;
            r_used <= n_used; r_mark <= n_mark;
        end
    end

    always_ff @(posedge i_clk) begin
        r_need <= n_need; r_y <= n_y; r_x <= n_x; r_cnt <= n_cnt; r_rsv <= n_rsv;
        r_pos <= n_pos; r_visit <= n_visit; r_id <= n_id; r_left <= n_left;
        r_st <= n_st; r_ra <= n_ra; r_chg <= n_chg;
        if (r_state == S_IDLE && i_start) r_cb <= w_cb;
    end

    assign o_busy           = (r_state != S_IDLE);
    assign o_done           = r_done;
    assign o_status         = r_st;
    assign o_result_address = r_ra;
    assign o_chunks_changed = r_chg;
    assign o_chunks_in_use  = r_used;
endmodule
`default_nettype wire

// ===== src/bica_checker.sv =====
// Port-level checker for the chunk allocator, bound to the top level.
// Depends on bica_pkg for status codes.
`default_nettype none
module bica_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_start,
    input wire logic        o_busy,
    input wire logic        o_done,
    input wire logic [1:0]  o_status,
    input wire logic [31:0] o_result_address,
    input wire logic [10:0] o_chunks_changed,
    input wire logic [10:0] o_chunks_in_use
);
    import bica_pkg::*;

    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy) else $error("busy not raised");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !o_busy) else $error("done while busy");
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("done repeated");
    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != ST_OK) |-> (o_result_address == '0 &&
        o_chunks_changed == '0)) else $error("failed word carries data");
    a_in_use_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_chunks_in_use <= 11'(MAX_CHUNKS)) else $error("in use too big");
endmodule

bind bitmap_id_chunk_allocator_top bica_checker u_bica_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
    .o_done(o_done), .o_status(o_status), .o_result_address(o_result_address),
    .o_chunks_changed(o_chunks_changed), .o_chunks_in_use(o_chunks_in_use)
);
`default_nettype wire
